// ===== design/hmms_pkg.sv =====
`default_nettype none

package hmms_pkg;

    typedef enum logic [2:0] {
        FUNC_HOST_READ   = 3'd0,
        FUNC_HOST_WRITE  = 3'd1,
        FUNC_HOST_RESET  = 3'd2,
        FUNC_PORT_A_WR   = 3'd3,
        FUNC_CONTROL_WR  = 3'd4,
        FUNC_STATUS_READ = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        WIRING_STANDARD = 2'd0,
        WIRING_INVERTED = 2'd1,
        WIRING_PORT_C   = 2'd2,
        WIRING_SPARE    = 2'd3
    } t_wiring;

    localparam logic [7:0] STATUS_BASE   = 8'hfc;
    localparam logic [7:0] STATUS_INVERT = 8'h03;
    localparam logic [7:0] STATUS_NO_MCU = 8'h02;
    localparam logic [7:0] BYTE_IDLE     = 8'hff;

    localparam logic [2:0] ACK_BIT_STD    = 3'd1;
    localparam logic [2:0] LOAD_BIT_STD   = 3'd2;
    localparam logic [2:0] ACK_BIT_PORTC  = 3'd2;
    localparam logic [2:0] LOAD_BIT_PORTC = 3'd3;

    typedef struct packed {
        logic       host_sem;
        logic       mcu_sem;
        logic       reset_held;
        logic       latch_driven;
        logic       semaphore_line;
        logic [7:0] host_latch;
        logic [7:0] mcu_latch;
        logic [7:0] port_a_out;
        logic [7:0] control_prev;
    } t_state;

    typedef struct packed {
        t_func      func;
        logic [7:0] data;
        logic       line_level;
        logic [7:0] byte_mask;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       mcu_irq;
        logic       mcu_reset;
        logic       host_semaphore;
        logic [7:0] port_a_drive;
        logic [5:0] aux_levels;
        logic [5:0] aux_toggled;
        logic [5:0] aux_falls;
        logic [7:0] strobe_data;
    } t_result;

endpackage

`default_nettype wire

// ===== design/hmms_step.sv =====
`default_nettype none

module hmms_step
    import hmms_pkg::*;
(
    input  var t_state  i_state,
    input  var t_item   i_item,
    input  var t_wiring i_variant,
    output t_state      o_state,
    output t_result     o_result
);

    logic       portc;
    logic [2:0] ack_bit;
    logic [2:0] load_bit;
    logic [7:0] pa_seen;
    logic [7:0] status;
    logic [7:0] read_data;
    logic [7:0] changed;
    logic [7:0] strobes;
    logic [7:0] sdata;
    t_state     nxt;

    assign portc    = (i_variant == WIRING_PORT_C);
    assign ack_bit  = portc ? ACK_BIT_PORTC : ACK_BIT_STD;
    assign load_bit = portc ? LOAD_BIT_PORTC : LOAD_BIT_STD;
    assign pa_seen  = i_state.port_a_out & (i_state.latch_driven ? i_state.host_latch : BYTE_IDLE);

    always_comb begin
        status = STATUS_BASE | {7'd0, i_state.host_sem}
               | (i_state.mcu_sem ? 8'd0 : STATUS_NO_MCU);
        if (i_variant == WIRING_INVERTED) begin
            status = status ^ STATUS_INVERT;
        end
    end

    always_comb begin
        nxt       = i_state;
        read_data = BYTE_IDLE;
        changed   = 8'd0;
        strobes   = 8'd0;
        sdata     = 8'd0;
        unique case (i_item.func)
            FUNC_HOST_READ: begin
                read_data          = i_state.mcu_latch;
                nxt.mcu_sem        = 1'b0;
                nxt.semaphore_line = 1'b0;
            end
            FUNC_HOST_WRITE: begin
                if (!i_state.reset_held) begin
                    nxt.host_sem = 1'b1;
                end
                nxt.host_latch = i_item.data;
            end
            FUNC_HOST_RESET: begin
                nxt.reset_held = i_item.line_level;
                if (i_item.line_level) begin
                    nxt.host_sem = 1'b0;
                    nxt.mcu_sem  = 1'b0;
                end
            end
            FUNC_PORT_A_WR: begin
                nxt.port_a_out = i_item.data;
            end
            FUNC_CONTROL_WR: begin
                sdata = pa_seen;
                if (!portc) begin
                    changed = i_item.data ^ i_state.control_prev;
                    strobes = i_item.byte_mask & ~i_item.data & i_state.control_prev;
                end
                // host-ack high releases the latch, rising edge clears host flag
                if (i_item.data[ack_bit]) begin
                    nxt.latch_driven = 1'b0;
                    if (!i_state.control_prev[ack_bit]) begin
                        nxt.host_sem = 1'b0;
                    end
                end else begin
                    nxt.latch_driven = 1'b1;
                end
                // load low sets mcu flag unless reset is held, falling edge captures port a
                if (!i_item.data[load_bit]) begin
                    if (!i_state.reset_held) begin
                        nxt.mcu_sem        = 1'b1;
                        nxt.semaphore_line = 1'b1;
                    end
                    if (i_state.control_prev[load_bit]) begin
                        nxt.mcu_latch = pa_seen;
                    end
                end
                nxt.control_prev = i_item.data;
            end
            FUNC_STATUS_READ: begin
                read_data = status;
            end
            default: begin
                read_data = BYTE_IDLE;
            end
        endcase
    end

    assign o_state = nxt;

    always_comb begin
        o_result.read_data      = read_data;
        o_result.mcu_irq        = nxt.host_sem;
        o_result.mcu_reset      = nxt.reset_held;
        o_result.host_semaphore = nxt.semaphore_line;
        o_result.port_a_drive   = nxt.latch_driven ? nxt.host_latch : BYTE_IDLE;
        o_result.aux_levels     = nxt.control_prev[7:2];
        o_result.aux_toggled    = changed[7:2];
        o_result.aux_falls      = strobes[7:2];
        o_result.strobe_data    = sdata;
    end

endmodule

`default_nettype wire

// ===== design/host_mcu_mailbox_semaphores_core.sv =====
// Host / microcontroller byte mailbox with semaphore flags.
// Input channel (s_axis): one word per bus access. tuser carries the access
// kind (host read, host write, host reset line, mcu port A write, mcu control
// write, mcu status read); tdata carries data, line level and byte mask.
// Output channel (m_axis): exactly one result word per accepted input word,
// holding the read byte, the irq/reset/semaphore lines, the port A drive and
// the aux strobe masks, all as they stand after the access.
// Configuration channel (cfg): a 2-bit wiring variant, written while idle;
// it is always ready and takes effect on the next access.
// A word accepted at a clock edge has its result registered and valid just
// after that edge. Throughput is one word per cycle while results are taken;
// the whole flag and latch update sits between the state and result registers.
// The input is ready whenever the result register is empty or being taken,
// so a stalled receiver holds the result and blocks further input, with no
// word lost or repeated.
// Reset clears both flags, the reset line, the semaphore and the drive
// enable, sets all latches and ports to 0xff and selects standard wiring.
`default_nettype none

module host_mcu_mailbox_semaphores_core
    import hmms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // data[7:0], line_level[8], byte_mask[16:9], zero fill
    input  wire logic [23:0] i_s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // read_data[7:0], mcu_irq[8], mcu_reset[9], host_semaphore[10],
    // port_a_drive[18:11], aux_levels[24:19], aux_toggled[30:25],
    // aux_falls[36:31], strobe_data[44:37], zero fill
    output logic [47:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data
);

    t_state  r_state;
    t_state  n_state;
    t_wiring r_variant;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    t_item   item;
    logic    accept;

    assign item.func       = t_func'(i_s_axis_tuser);
    assign item.data       = i_s_axis_tdata[7:0];
    assign item.line_level = i_s_axis_tdata[8];
    assign item.byte_mask  = i_s_axis_tdata[16:9];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    hmms_step u_step (
        .i_state   (r_state),
        .i_item    (item),
        .i_variant (r_variant),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.host_sem       <= 1'b0;
            r_state.mcu_sem        <= 1'b0;
            r_state.reset_held     <= 1'b0;
            r_state.latch_driven   <= 1'b0;
            r_state.semaphore_line <= 1'b0;
            r_state.host_latch     <= BYTE_IDLE;
            r_state.mcu_latch      <= BYTE_IDLE;
            r_state.port_a_out     <= BYTE_IDLE;
            r_state.control_prev   <= BYTE_IDLE;
            r_variant              <= WIRING_STANDARD;
            r_out_valid            <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_variant <= t_wiring'(i_cfg_data);
            end
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.strobe_data, r_out.aux_falls, r_out.aux_toggled,
                              r_out.aux_levels, r_out.port_a_drive, r_out.host_semaphore,
                              r_out.mcu_reset, r_out.mcu_irq, r_out.read_data};

    a_irq_tracks_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.mcu_irq == r_state.host_sem)
        else $error("irq in result differs from host flag");

    a_levels_track_control: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.aux_levels == r_state.control_prev[7:2])
        else $error("aux levels differ from control register");

    a_reset_blocks_host_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && item.func == FUNC_HOST_WRITE && r_state.reset_held)
        |=> r_state.host_sem == $past(r_state.host_sem))
        else $error("host flag set while reset held");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb
    import hmms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic [2:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = '0;
    logic        hold_off = 1'b0;

    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [47:0] m_data;
    wire logic        cfg_ready;

    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;

    t_state  mbx_state;
    t_wiring wiring;
    t_result pending_replies[$];

    host_mcu_mailbox_semaphores_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // predicted effect of one access, state updated in place
    function automatic t_result mbx_access(input logic [2:0] fn, input logic [7:0] d,
                                           input logic lvl, input logic [7:0] msk);
        t_result    r;
        logic       portc;
        logic [2:0] ack_b;
        logic [2:0] load_b;
        logic [7:0] pa_old;
        logic [7:0] prev;
        logic [7:0] diff;
        logic [7:0] fall;
        logic [7:0] stat;
        r = '0;
        r.read_data = BYTE_IDLE;
        case (fn)
            FUNC_HOST_READ: begin
                r.read_data = mbx_state.mcu_latch;
                mbx_state.mcu_sem = 1'b0;
                mbx_state.semaphore_line = 1'b0;
            end
            FUNC_HOST_WRITE: begin
                if (!mbx_state.reset_held) mbx_state.host_sem = 1'b1;
                mbx_state.host_latch = d;
            end
            FUNC_HOST_RESET: begin
                mbx_state.reset_held = lvl;
                if (lvl) begin
                    mbx_state.host_sem = 1'b0;
                    mbx_state.mcu_sem = 1'b0;
                end
            end
            FUNC_PORT_A_WR: begin
                mbx_state.port_a_out = d;
            end
            FUNC_CONTROL_WR: begin
                portc = (wiring == WIRING_PORT_C);
                ack_b = portc ? ACK_BIT_PORTC : ACK_BIT_STD;
                load_b = portc ? LOAD_BIT_PORTC : LOAD_BIT_STD;
                pa_old = mbx_state.port_a_out
                       & (mbx_state.latch_driven ? mbx_state.host_latch : BYTE_IDLE);
                prev = mbx_state.control_prev;
                r.strobe_data = pa_old;
                if (!portc) begin
                    diff = d ^ prev;
                    fall = msk & ~d & prev;
                    r.aux_toggled = diff[7:2];
                    r.aux_falls = fall[7:2];
                end
                if (d[ack_b]) begin
                    mbx_state.latch_driven = 1'b0;
                    if (!prev[ack_b]) mbx_state.host_sem = 1'b0;
                end else begin
                    mbx_state.latch_driven = 1'b1;
                end
                if (!d[load_b]) begin
                    if (!mbx_state.reset_held) begin
                        mbx_state.mcu_sem = 1'b1;
                        mbx_state.semaphore_line = 1'b1;
                    end
                    if (prev[load_b]) mbx_state.mcu_latch = pa_old;
                end
                mbx_state.control_prev = d;
            end
            FUNC_STATUS_READ: begin
                stat = STATUS_BASE | {7'd0, mbx_state.host_sem}
                     | (mbx_state.mcu_sem ? 8'h00 : STATUS_NO_MCU);
                if (wiring == WIRING_INVERTED) stat = stat ^ STATUS_INVERT;
                r.read_data = stat;
            end
            default: begin
            end
        endcase
        r.mcu_irq = mbx_state.host_sem;
        r.mcu_reset = mbx_state.reset_held;
        r.host_semaphore = mbx_state.semaphore_line;
        r.port_a_drive = mbx_state.latch_driven ? mbx_state.host_latch : BYTE_IDLE;
        r.aux_levels = mbx_state.control_prev[7:2];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge clk) begin
        m_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got.read_data      = m_data[7:0];
            got.mcu_irq        = m_data[8];
            got.mcu_reset      = m_data[9];
            got.host_semaphore = m_data[10];
            got.port_a_drive   = m_data[18:11];
            got.aux_levels     = m_data[24:19];
            got.aux_toggled    = m_data[30:25];
            got.aux_falls      = m_data[36:31];
            got.strobe_data    = m_data[44:37];
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected word", 8'h00, 8'h00);
            end else begin
                want = pending_replies.pop_front();
                check_field("read_data", got.read_data, want.read_data);
                check_field("mcu_irq", 8'(got.mcu_irq), 8'(want.mcu_irq));
                check_field("mcu_reset", 8'(got.mcu_reset), 8'(want.mcu_reset));
                check_field("host_semaphore", 8'(got.host_semaphore),
                            8'(want.host_semaphore));
                check_field("port_a_drive", got.port_a_drive, want.port_a_drive);
                check_field("aux_levels", 8'(got.aux_levels), 8'(want.aux_levels));
                check_field("aux_toggled", 8'(got.aux_toggled), 8'(want.aux_toggled));
                check_field("aux_falls", 8'(got.aux_falls), 8'(want.aux_falls));
                check_field("strobe_data", got.strobe_data, want.strobe_data);
            end
        end
    end

    task automatic send_access(input logic [2:0] fn, input logic [7:0] d,
                               input logic lvl, input logic [7:0] msk);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'd0, msk, lvl, d};
        s_user  <= fn;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        pending_replies.push_back(mbx_access(fn, d, lvl, msk));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_wiring(input t_wiring v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        wiring = v;
    endtask

    task automatic set_pacing(input int unsigned gap, input int unsigned stall);
        gap_pct = gap;
        stall_pct = stall;
    endtask

    task automatic random_access;
        int unsigned roll;
        logic [7:0]  d;
        roll = $urandom_range(99);
        d = 8'($urandom);
        if (roll < 14)
            send_access(FUNC_HOST_READ, d, 1'($urandom), 8'($urandom));
        else if (roll < 28)
            send_access(FUNC_HOST_WRITE, d, 1'($urandom), 8'($urandom));
        else if (roll < 33)
            send_access(FUNC_HOST_RESET, d, $urandom_range(99) < 30, 8'($urandom));
        else if (roll < 44)
            send_access(FUNC_PORT_A_WR, $urandom_range(1) ? BYTE_IDLE : d, 1'($urandom),
                        8'($urandom));
        else if (roll < 78)
            send_access(FUNC_CONTROL_WR, d, 1'($urandom), 8'($urandom));
        else if (roll < 90)
            send_access(FUNC_STATUS_READ, d, 1'($urandom), 8'($urandom));
        else
            send_access(3'($urandom_range(7, 6)), d, 1'($urandom), 8'($urandom));
    endtask

    // one host-to-mcu and mcu-to-host round trip with random payloads
    task automatic mailbox_exchange;
        logic [2:0] ack_b;
        logic [2:0] load_b;
        logic [7:0] ctl;
        ack_b = (wiring == WIRING_PORT_C) ? ACK_BIT_PORTC : ACK_BIT_STD;
        load_b = (wiring == WIRING_PORT_C) ? LOAD_BIT_PORTC : LOAD_BIT_STD;
        send_access(FUNC_HOST_WRITE, 8'($urandom), 1'($urandom), 8'($urandom));
        ctl = 8'($urandom);
        ctl[ack_b] = 1'b0;
        ctl[load_b] = 1'b1;
        send_access(FUNC_CONTROL_WR, ctl, 1'($urandom), 8'($urandom));
        send_access(FUNC_PORT_A_WR, ($urandom_range(3) != 0) ? BYTE_IDLE : 8'($urandom),
                    1'($urandom), 8'($urandom));
        ctl = 8'($urandom);
        ctl[ack_b] = 1'b0;
        ctl[load_b] = 1'b0;
        send_access(FUNC_CONTROL_WR, ctl, 1'($urandom), 8'($urandom));
        send_access(FUNC_STATUS_READ, 8'($urandom), 1'($urandom), 8'($urandom));
        ctl = 8'($urandom);
        ctl[ack_b] = 1'b1;
        ctl[load_b] = 1'b1;
        send_access(FUNC_CONTROL_WR, ctl, 1'($urandom), 8'($urandom));
        send_access(FUNC_HOST_READ, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic test_idle_values;
        send_access(FUNC_STATUS_READ, 8'h00, 1'b0, 8'h00);
        send_access(FUNC_HOST_READ, 8'hff, 1'b1, 8'hff);
        send_access(3'd6, 8'h00, 1'b0, 8'h00);
        send_access(3'd7, 8'hff, 1'b1, 8'hff);
        drain();
    endtask

    task automatic test_host_to_mcu;
        send_access(FUNC_HOST_WRITE, 8'h00, 1'b0, 8'h00);
        send_access(FUNC_CONTROL_WR, 8'hfd, 1'b0, 8'h00);
        send_access(FUNC_CONTROL_WR, 8'hf9, 1'b0, 8'hff);
        send_access(FUNC_HOST_READ, 8'h00, 1'b0, 8'h00);
        send_access(FUNC_CONTROL_WR, 8'hff, 1'b0, 8'h00);
        send_access(FUNC_HOST_WRITE, 8'hff, 1'b0, 8'h00);
        send_access(FUNC_PORT_A_WR, 8'h00, 1'b0, 8'h00);
        send_access(FUNC_STATUS_READ, 8'h00, 1'b0, 8'h00);
        drain();
    endtask

    task automatic test_reset_line;
        send_access(FUNC_HOST_RESET, 8'h00, 1'b1, 8'h00);
        send_access(FUNC_HOST_WRITE, 8'h5a, 1'b0, 8'h00);
        send_access(FUNC_CONTROL_WR, 8'h00, 1'b0, 8'hff);
        send_access(FUNC_STATUS_READ, 8'h00, 1'b0, 8'h00);
        send_access(FUNC_HOST_RESET, 8'hff, 1'b0, 8'hff);
        drain();
    endtask

    task automatic test_wiring_variants;
        write_wiring(WIRING_INVERTED);
        send_access(FUNC_STATUS_READ, 8'h00, 1'b0, 8'h00);
        drain();
        write_wiring(WIRING_PORT_C);
        send_access(FUNC_CONTROL_WR, 8'hf3, 1'b0, 8'hff);
        send_access(FUNC_CONTROL_WR, 8'hff, 1'b0, 8'hff);
        drain();
        write_wiring(WIRING_SPARE);
        send_access(FUNC_CONTROL_WR, 8'h00, 1'b0, 8'hff);
        send_access(FUNC_STATUS_READ, 8'h00, 1'b0, 8'h00);
        drain();
        write_wiring(WIRING_STANDARD);
    endtask

    task automatic test_receiver_holdoff;
        fork
            begin
                hold_off <= 1'b1;
                repeat (80) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (30) random_access();
            end
        join
        drain();
    endtask

    task automatic test_random_traffic;
        t_wiring     order[8];
        int unsigned sent;
        order = '{WIRING_STANDARD, WIRING_INVERTED, WIRING_PORT_C, WIRING_SPARE,
                  WIRING_PORT_C, WIRING_STANDARD, WIRING_INVERTED, WIRING_SPARE};
        for (int seg = 0; seg < 8; seg++) begin
            case (seg % 4)
                0: set_pacing(0, 0);
                1: set_pacing(59, 0);
                2: set_pacing(0, 59);
                default: set_pacing(32, 32);
            endcase
            write_wiring(order[seg]);
            sent = 0;
            while (sent < 128) begin
                if ($urandom_range(99) < 35) begin
                    mailbox_exchange();
                    sent += 7;
                end else begin
                    random_access();
                    sent++;
                end
            end
            drain();
        end
        set_pacing(0, 0);
    endtask

    initial begin
        mbx_state = '{host_sem: 1'b0, mcu_sem: 1'b0, reset_held: 1'b0,
                      latch_driven: 1'b0, semaphore_line: 1'b0,
                      host_latch: BYTE_IDLE, mcu_latch: BYTE_IDLE,
                      port_a_out: BYTE_IDLE, control_prev: BYTE_IDLE};
        wiring = WIRING_STANDARD;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_values();
        test_host_to_mcu();
        test_reset_line();
        test_wiring_variants();
        test_receiver_holdoff();
        test_random_traffic();
        set_pacing(32, 32);
        test_receiver_holdoff();

        drain();
        repeat (8) @(posedge clk);
        if (pending_replies.size() != 0)
            report_mismatch("words never returned", 8'(pending_replies.size()), 8'h00);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
